// ----- design/assert_macros.svh -----
// Assertion macros used by rotation_matrix_derivative_core.
// No dependencies; the checks are left out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- design/rmd_pkg.sv -----
// Shared constants, types and functions for the rotation matrix derivative core.
// No dependencies.
package rmd_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int ENTRY_FRAC_BITS = 14;
    localparam int ENTRY_W         = 16;
    localparam int PHI_W           = 32;
    localparam int CORDIC_STAGES   = 30;
    localparam int CORDIC_FRAC     = 30;
    localparam int XY_W            = 34;
    localparam int Z_W             = 33;
    localparam int ROUND_SH        = CORDIC_FRAC - ENTRY_FRAC_BITS;

    localparam logic [PHI_W-1:0] QUARTER_TURN = PHI_W'(32'h4000_0000);
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = XY_W'(652032875);
    localparam logic signed [XY_W-1:0] ENTRY_ONE = XY_W'(1) <<< ENTRY_FRAC_BITS;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_BAD = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0] axis_code;
        logic [1:0] quad;
    } rmd_side_t;

    typedef struct packed {
        logic                   valid;
        rmd_side_t              side;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } rmd_tail_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return Z_W'(v);
    endfunction

    // round half up to the entry fraction and clamp to +-1.0
    function automatic logic signed [ENTRY_W-1:0] to_entry(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + (XY_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r > ENTRY_ONE)
            r = ENTRY_ONE;
        if (r < -ENTRY_ONE)
            r = -ENTRY_ONE;
        return r[ENTRY_W-1:0];
    endfunction

endpackage

// ----- design/rmd_cordic.sv -----
// Pipelined rotation-mode CORDIC, one iteration per stage, first quadrant only.
// Depends on rmd_pkg.
module rmd_cordic import rmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  load,
    input  logic signed [Z_W-1:0] z_in,
    input  rmd_side_t             side_in,
    output rmd_tail_t             tail
);

    logic                   valid_reg [0:CORDIC_STAGES];
    rmd_side_t              side_reg  [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] x_reg     [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] y_reg     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg     [0:CORDIC_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= side_in;
            x_reg[0]    <= CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_in;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;

        always_comb
        begin
            if (!z_reg[k][Z_W-1])
            begin
                x_next = x_reg[k] - dx;
                y_next = y_reg[k] + dy;
                z_next = z_reg[k] - atan_turn(k);
            end
            else
            begin
                x_next = x_reg[k] + dx;
                y_next = y_reg[k] - dy;
                z_next = z_reg[k] + atan_turn(k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                side_reg[k+1] <= side_reg[k];
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
            end
        end
    end

    assign tail.valid = valid_reg[CORDIC_STAGES];
    assign tail.side  = side_reg[CORDIC_STAGES];
    assign tail.x     = x_reg[CORDIC_STAGES];
    assign tail.y     = y_reg[CORDIC_STAGES];

endmodule

// ----- design/rotation_matrix_derivative_core.sv -----
// An accepted item word passes the input register, the CORDIC stages and the result register.
// Throughput: one word per cycle; the 30-stage CORDIC pipeline and the result
// register advance together and halt only while a valid result is stalled.
// Reset: asynchronous, active low; clears all valid bits, no clearing pass.
// Top level: quadrant fold, CORDIC pipeline, rounding and matrix assembly.
// Depends on rmd_pkg, rmd_cordic and assert_macros.svh.
`include "assert_macros.svh"
module rotation_matrix_derivative_core import rmd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic signed [ENTRY_W-1:0] angle,
    input  logic [1:0]                axis_code,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic signed [ENTRY_W-1:0] r0c0,
    output logic signed [ENTRY_W-1:0] r0c1,
    output logic signed [ENTRY_W-1:0] r0c2,
    output logic signed [ENTRY_W-1:0] r1c0,
    output logic signed [ENTRY_W-1:0] r1c1,
    output logic signed [ENTRY_W-1:0] r1c2,
    output logic signed [ENTRY_W-1:0] r2c0,
    output logic signed [ENTRY_W-1:0] r2c1,
    output logic signed [ENTRY_W-1:0] r2c2,
    output logic                      bad_axis
);

    logic                   advance;
    logic [PHI_W-1:0]       phi;
    logic signed [Z_W-1:0]  z_in;
    rmd_side_t              side_in;
    rmd_tail_t              tail;
    logic signed [ENTRY_W-1:0] sr;
    logic signed [ENTRY_W-1:0] cr;
    logic signed [ENTRY_W-1:0] s;
    logic signed [ENTRY_W-1:0] c;
    logic signed [ENTRY_W-1:0] m_next [0:8];
    logic signed [ENTRY_W-1:0] m_reg  [0:8];
    logic                   bad_next;
    logic                   bad_reg;
    logic                   result_valid_reg;

    assign advance    = !(result_valid_reg && result_stall);
    assign item_stall = !advance;

    assign phi = (PHI_W'(angle[ANGLE_BITS-1:0]) << (PHI_W - ANGLE_BITS)) + QUARTER_TURN;
    assign z_in = Z_W'(phi[PHI_W-3:0]);
    assign side_in.axis_code = axis_code;
    assign side_in.quad      = phi[PHI_W-1:PHI_W-2];

    rmd_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .load    (item_valid),
        .z_in    (z_in),
        .side_in (side_in),
        .tail    (tail)
    );

    assign sr = to_entry(tail.y);
    assign cr = to_entry(tail.x);

    always_comb
    begin
        case (tail.side.quad)
            QUAD_0:
            begin
                s = sr;
                c = cr;
            end
            QUAD_1:
            begin
                s = cr;
                c = -sr;
            end
            QUAD_2:
            begin
                s = -sr;
                c = -cr;
            end
            default:
            begin
                s = -cr;
                c = sr;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_next[k] = '0;
        end
        bad_next = 1'b0;
        case (tail.side.axis_code)
            AXIS_X:
            begin
                m_next[4] = c;
                m_next[5] = -s;
                m_next[7] = s;
                m_next[8] = c;
            end
            AXIS_Y:
            begin
                m_next[0] = c;
                m_next[2] = -s;
                m_next[6] = s;
                m_next[8] = c;
            end
            AXIS_Z:
            begin
                m_next[0] = c;
                m_next[1] = -s;
                m_next[3] = s;
                m_next[4] = c;
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_reg   <= m_next;
            bad_reg <= bad_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign r0c0 = m_reg[0];
    assign r0c1 = m_reg[1];
    assign r0c2 = m_reg[2];
    assign r1c0 = m_reg[3];
    assign r1c1 = m_reg[4];
    assign r1c2 = m_reg[5];
    assign r2c0 = m_reg[6];
    assign r2c1 = m_reg[7];
    assign r2c2 = m_reg[8];
    assign bad_axis = bad_reg;

    `ASSERT_CLK(a_bad_zero, clk, rst_n,
        result_valid && bad_axis |-> r0c0 == 0 && r0c1 == 0 && r0c2 == 0
        && r1c0 == 0 && r1c1 == 0 && r1c2 == 0 && r2c0 == 0 && r2c1 == 0 && r2c2 == 0)
    `ASSERT_CLK(a_axis_zero, clk, rst_n,
        result_valid && !bad_axis |->
        (r0c0 == 0 && r0c1 == 0 && r0c2 == 0 && r1c0 == 0 && r2c0 == 0)
        || (r1c0 == 0 && r1c1 == 0 && r1c2 == 0 && r0c1 == 0 && r2c1 == 0)
        || (r2c0 == 0 && r2c1 == 0 && r2c2 == 0 && r0c2 == 0 && r1c2 == 0))
    `ASSERT_CLK(a_range, clk, rst_n,
        result_valid |-> r0c0 <= ENTRY_W'(16384) && r0c0 >= -ENTRY_W'(16384)
        && r1c1 <= ENTRY_W'(16384) && r1c1 >= -ENTRY_W'(16384)
        && r2c2 <= ENTRY_W'(16384) && r2c2 >= -ENTRY_W'(16384))
    `ASSERT_CLK(a_hold_stalled, clk, rst_n,
        result_valid && result_stall |=> result_valid && $stable(bad_axis))

endmodule

// ----- sim/tb.sv -----
// Testbench for rotation_matrix_derivative_core: random and directed angle/axis words
// with its own CORDIC predictor and field-by-field result checks.
// Depends on rmd_pkg and the core RTL only.
module tb;
    import rmd_pkg::*;

    localparam int RANDOM_WORDS = 1650;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 64;

    localparam longint ARCTAN_TURN [0:CORDIC_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic                      hold;
        logic signed [ENTRY_W-1:0] angle;
        logic [1:0]                axis_code;
    } angle_word_t;

    typedef struct packed {
        logic [8:0][ENTRY_W-1:0] m;
        logic                    bad;
    } matrix_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic signed [ENTRY_W-1:0] angle = '0;
    logic [1:0] axis_code = AXIS_X;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [ENTRY_W-1:0] r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;
    logic bad_axis;

    angle_word_t  pending_words [$];
    matrix_word_t expected_mats [$];

    string field_name [9] = '{"r0c0", "r0c1", "r0c2", "r1c0", "r1c1", "r1c2",
                              "r2c0", "r2c1", "r2c2"};

    int  errors = 0;
    int  words_in = 0;
    int  mats_out = 0;
    int  bad_out = 0;
    int  drains = 0;
    int  idle_cycles = 0;
    bit  item_taken = 0;
    int  send_gap = 0;
    bit  send_quiet = 0;
    int  stall_left = 0;
    int  flow_left = 0;
    bit  recv_quiet = 0;

    rotation_matrix_derivative_core uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .angle(angle), .axis_code(axis_code),
        .result_valid(result_valid), .result_stall(result_stall),
        .r0c0(r0c0), .r0c1(r0c1), .r0c2(r0c2),
        .r1c0(r1c0), .r1c1(r1c1), .r1c2(r1c2),
        .r2c0(r2c0), .r2c1(r2c1), .r2c2(r2c2),
        .bad_axis(bad_axis)
    );

    always #5 clk = ~clk;

    function automatic longint round_entry(input longint v);
        longint r;
        longint one;
        one = longint'(1) <<< ENTRY_FRAC_BITS;
        r = (v + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r > one)
            r = one;
        if (r < -one)
            r = -one;
        return r;
    endfunction

    function automatic void sin_cos_q14(input logic [31:0] phi, output longint s,
                                        output longint c);
        longint x, y, z, dx, dy, sr, cr;
        x = longint'(CORDIC_GAIN_INV);
        y = 0;
        z = longint'(phi[29:0]);
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_TURN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_TURN[i];
            end
        end
        sr = round_entry(y);
        cr = round_entry(x);
        case (phi[31:30])
            QUAD_0:
            begin
                s = sr;
                c = cr;
            end
            QUAD_1:
            begin
                s = cr;
                c = -sr;
            end
            QUAD_2:
            begin
                s = -sr;
                c = -cr;
            end
            default:
            begin
                s = -cr;
                c = sr;
            end
        endcase
    endfunction

    function automatic matrix_word_t predict_derivative(input logic [ENTRY_W-1:0] a,
                                                        input logic [1:0] axis);
        matrix_word_t w;
        logic [31:0] phi;
        longint s, c;
        phi = 32'(a[ANGLE_BITS-1:0]) << (PHI_W - ANGLE_BITS);
        phi = phi + QUARTER_TURN;
        sin_cos_q14(phi, s, c);
        w = '0;
        case (axis)
            AXIS_X:
            begin
                w.m[4] = ENTRY_W'(c);
                w.m[5] = ENTRY_W'(-s);
                w.m[7] = ENTRY_W'(s);
                w.m[8] = ENTRY_W'(c);
            end
            AXIS_Y:
            begin
                w.m[0] = ENTRY_W'(c);
                w.m[2] = ENTRY_W'(-s);
                w.m[6] = ENTRY_W'(s);
                w.m[8] = ENTRY_W'(c);
            end
            AXIS_Z:
            begin
                w.m[0] = ENTRY_W'(c);
                w.m[1] = ENTRY_W'(-s);
                w.m[3] = ENTRY_W'(s);
                w.m[4] = ENTRY_W'(c);
            end
            default:
                w.bad = 1'b1;
        endcase
        return w;
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ENTRY_W-1:0] random_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return ENTRY_W'($urandom);
        if (r < 88)
            return ENTRY_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3);
        if (r < 94)
            return ENTRY_W'($urandom_range(0, 7) * 8192);
        return ENTRY_W'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
    endfunction

    // monitor: accept words, predict, check results
    always @(posedge clk)
    begin
        matrix_word_t got, want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                expected_mats.push_back(predict_derivative(angle, axis_code));
                words_in++;
                item_taken = 1;
            end
            if (result_valid && !result_stall)
            begin
                got.m = {r2c2, r2c1, r2c0, r1c2, r1c1, r1c0, r0c2, r0c1, r0c0};
                got.bad = bad_axis;
                mats_out++;
                if (bad_axis)
                    bad_out++;
                if (expected_mats.size() == 0)
                    report("result word with nothing expected");
                else
                begin
                    want = expected_mats.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got.m[k] !== want.m[k])
                            report($sformatf("%s got %0d want %0d", field_name[k],
                                             $signed(got.m[k]), $signed(want.m[k])));
                    if (got.bad !== want.bad)
                        report($sformatf("bad_axis got %b want %b", got.bad, want.bad));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        angle_word_t w;
        bit next_valid;
        if (rst_n && (!item_valid || item_taken))
        begin
            item_taken = 0;
            next_valid = 0;
            if (send_gap > 0)
                send_gap--;
            else if (pending_words.size() > 0)
            begin
                if (!pending_words[0].hold || expected_mats.size() == 0)
                begin
                    w = pending_words.pop_front();
                    if (w.hold)
                        drains++;
                    angle <= w.angle;
                    axis_code <= w.axis_code;
                    next_valid = 1;
                    if ($urandom_range(0, 99) < 3)
                        send_quiet = !send_quiet;
                    send_gap = pick_gap(send_quiet);
                end
            end
            item_valid <= next_valid;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            result_stall <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) < 5)
                recv_quiet = !recv_quiet;
            flow_left = recv_quiet ? 40 : $urandom_range(0, 8);
            stall_left = pick_gap(recv_quiet);
            result_stall <= 1'b0;
        end
    end

    initial
    begin
        logic signed [ENTRY_W-1:0] edge_angles [12] = '{
            16'sd0, 16'sd16384, -16'sd32768, -16'sd16384, 16'sd32767, -16'sd1,
            16'sd1, 16'sd8192, -16'sd8192, 16'sh5555, 16'sh2AAA, 16'sd16383
        };
        angle_word_t w;

        foreach (edge_angles[i])
        begin
            w.hold = 1'b0;
            w.angle = edge_angles[i];
            w.axis_code = 2'(i % 4);
            pending_words.push_back(w);
        end
        for (int ax = 0; ax < 4; ax++)
        begin
            w.hold = 1'b0;
            w.angle = 16'sd16384;
            w.axis_code = 2'(ax);
            pending_words.push_back(w);
            w.angle = 16'sh8000;
            pending_words.push_back(w);
        end
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            w.hold = (n == 0 || n == 500 || n == 1200);
            w.angle = random_angle();
            w.axis_code = ($urandom_range(0, 9) == 0) ? AXIS_BAD
                                                      : 2'($urandom_range(0, 2));
            pending_words.push_back(w);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && !item_valid);
        wait (expected_mats.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_mats.size() != 0)
            report($sformatf("%0d result words never arrived", expected_mats.size()));

        $display("sent %0d angle words over all axes and quadrants, %0d drain pauses",
                 words_in, drains);
        $display("checked %0d matrix words, %0d with invalid axis", mats_out, bad_out);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
